// ===== hw/rtl/coalescing_interval_set_top_assert.svh =====
// Assertion macros used by the interval set RTL.
// Included by cis_ctrl to check its own control logic; no other dependencies.
`ifndef COALESCING_INTERVAL_SET_TOP_ASSERT_SVH
`define COALESCING_INTERVAL_SET_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIS_ASSERT_HOLDS(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CIS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cis_pkg.sv =====
// Package for the coalescing interval set: beat types, opcodes, status codes, defaults.
// No dependencies; used by cis_ctrl and coalescing_interval_set_top.
`default_nettype none

package cis_pkg;

  localparam int MAX_RANGES_DEF = 256;
  localparam int LINE_BITS_DEF  = 24;

  localparam int POS_W      = 24;
  localparam int INDEX_W    = 8;
  localparam int OUT_LINE_W = 24;
  localparam int COUNT_W    = 9;
  localparam int STATUS_W   = 3;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_COVERED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXT_PREV = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXT_NEXT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_JOINED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd6;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd7;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [POS_W-1:0]   position;
    logic [INDEX_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_LINE_W-1:0] range_start;
    logic [OUT_LINE_W-1:0] range_end;
    logic [COUNT_W-1:0]    range_count;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } fin_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cis_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module cis_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cis_ctrl.sv =====
// Sequencer of the interval set: binary search, neighbor fetch, merge decision and
// the one-entry-per-cycle shift through the range RAM. Depends on cis_pkg and the
// assertion header.
`default_nettype none
`include "coalescing_interval_set_top_assert.svh"

module cis_ctrl #(
  parameter int MAX_RANGES = cis_pkg::MAX_RANGES_DEF,
  parameter int LINE_BITS  = cis_pkg::LINE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire cis_pkg::cmd_t                 cmd,
  output logic                               busy,
  output logic                               ram_we,
  output logic [$clog2(MAX_RANGES)-1:0]      ram_waddr,
  output logic [2*LINE_BITS-1:0]             ram_wdata,
  output logic [$clog2(MAX_RANGES)-1:0]      ram_raddr,
  input  wire logic [2*LINE_BITS-1:0]        ram_rdata,
  output cis_pkg::fin_t                      fin
);

  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int LB = LINE_BITS;
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_BS, S_BS_CMP, S_NB_PREV, S_GET_PREV,
    S_NB_NEXT, S_GET_NEXT, S_DECIDE, S_SHIFT
  } state_t;

  state_t state;
  logic [CW-1:0] n;
  logic [LB-1:0] pos;
  logic [CW-1:0] lo, hi, mid_q, nxt, src, dst, cnt;
  logic          have_prev, have_next, rd_pend, is_join;
  logic [LB-1:0] prev_first, prev_last, next_first, next_last;

  logic [LB-1:0]    rd_first, rd_last;
  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid_full;
  logic [CW-1:0]    prev_slot;
  logic [LB+23:0]   pos_ext;
  logic [LB-1:0]    pos_in;
  logic [CW+7:0]    idx_w, n_w;
  logic             idx_ok;
  logic             d_cov, d_gp, d_gn, d_full;
  logic [LB-1:0]    done_first, done_last;
  logic [LB+23:0]   first_x, last_x;
  logic [CW-1:0]    done_count;
  logic [CW+8:0]    count_x;

  assign rd_first  = ram_rdata[2*LB-1:LB];
  assign rd_last   = ram_rdata[LB-1:0];
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid_full  = mid_sum[CW:1];
  assign prev_slot = nxt - ONE_C;
  assign pos_ext   = {{LB{1'b0}}, cmd.position};
  assign pos_in    = pos_ext[LB-1:0];
  assign idx_w     = {{CW{1'b0}}, cmd.index};
  assign n_w       = {8'd0, n};
  assign idx_ok    = idx_w < n_w;
  assign busy      = (state != S_IDLE);

  // Merge decision on the two neighbors; adjacency is tested one bit wider so the
  // top line never wraps.
  assign d_cov  = have_prev && (pos <= prev_last);
  assign d_gp   = have_prev && (({1'b0, prev_last} + 1'b1) == {1'b0, pos});
  assign d_gn   = have_next && ({1'b0, next_first} == ({1'b0, pos} + 1'b1));
  assign d_full = (n == MAX_CNT);

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    fin.valid  = 1'b0;
    fin.res.status = cis_pkg::ST_EMPTY;
    done_first = '0;
    done_last  = '0;
    done_count = n;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd.opcode)
            cis_pkg::OP_CLEAR: begin
              fin.valid  = 1'b1;
              done_count = '0;
            end
            cis_pkg::OP_READ: begin
              ram_raddr = idx_w[AW-1:0];
              fin.valid = !idx_ok;
            end
            cis_pkg::OP_INSERT: begin
            end
            default: begin
              fin.valid = 1'b1;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        fin.valid      = 1'b1;
        fin.res.status = cis_pkg::ST_READ_OK;
        done_first     = rd_first;
        done_last      = rd_last;
      end
      S_BS:       ram_raddr = mid_full[AW-1:0];
      S_BS_CMP:   ;
      S_NB_PREV:  ram_raddr = prev_slot[AW-1:0];
      S_GET_PREV: ;
      S_NB_NEXT:  ram_raddr = nxt[AW-1:0];
      S_GET_NEXT: ;
      S_DECIDE: begin
        priority if (d_cov) begin
          fin.valid      = 1'b1;
          fin.res.status = cis_pkg::ST_COVERED;
          done_first     = prev_first;
          done_last      = prev_last;
        end else if (d_gp && d_gn) begin
          ram_we    = 1'b1;
          ram_waddr = prev_slot[AW-1:0];
          ram_wdata = {prev_first, next_last};
        end else if (d_gp) begin
          ram_we         = 1'b1;
          ram_waddr      = prev_slot[AW-1:0];
          ram_wdata      = {prev_first, pos};
          fin.valid      = 1'b1;
          fin.res.status = cis_pkg::ST_EXT_PREV;
          done_first     = prev_first;
          done_last      = pos;
        end else if (d_gn) begin
          ram_we         = 1'b1;
          ram_waddr      = nxt[AW-1:0];
          ram_wdata      = {pos, next_last};
          fin.valid      = 1'b1;
          fin.res.status = cis_pkg::ST_EXT_NEXT;
          done_first     = pos;
          done_last      = next_last;
        end else if (d_full) begin
          fin.valid      = 1'b1;
          fin.res.status = cis_pkg::ST_FULL;
          done_first     = pos;
          done_last      = pos;
        end else begin
        end
      end
      S_SHIFT: begin
        // Read data lands in the cycle after its address; it is written to the
        // neighboring slot while the next source is read.
        if (rd_pend) begin
          ram_we    = 1'b1;
          ram_waddr = dst[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (cnt != '0) begin
          ram_raddr = src[AW-1:0];
        end else if (!rd_pend) begin
          fin.valid = 1'b1;
          if (is_join) begin
            fin.res.status = cis_pkg::ST_JOINED;
            done_first     = prev_first;
            done_last      = next_last;
            done_count     = n - ONE_C;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = nxt[AW-1:0];
            ram_wdata      = {pos, pos};
            fin.res.status = cis_pkg::ST_NEW;
            done_first     = pos;
            done_last      = pos;
            done_count     = n + ONE_C;
          end
        end
      end
    endcase
    first_x = {24'd0, done_first};
    last_x  = {24'd0, done_last};
    count_x = {9'd0, done_count};
    fin.res.range_start = first_x[cis_pkg::OUT_LINE_W-1:0];
    fin.res.range_end   = last_x[cis_pkg::OUT_LINE_W-1:0];
    fin.res.range_count = count_x[cis_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      n       <= '0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (cmd.opcode)
              cis_pkg::OP_CLEAR: n <= '0;
              cis_pkg::OP_READ: begin
                if (idx_ok) begin
                  state <= S_RD_WAIT;
                end
              end
              cis_pkg::OP_INSERT: begin
                pos   <= pos_in;
                lo    <= '0;
                hi    <= n;
                state <= S_BS;
              end
              default: ;
            endcase
          end
        end
        S_RD_WAIT: state <= S_IDLE;
        S_BS: begin
          if (lo < hi) begin
            mid_q <= mid_full;
            state <= S_BS_CMP;
          end else begin
            nxt   <= lo;
            state <= S_NB_PREV;
          end
        end
        S_BS_CMP: begin
          if (rd_first <= pos) begin
            lo <= mid_q + ONE_C;
          end else begin
            hi <= mid_q;
          end
          state <= S_BS;
        end
        S_NB_PREV: begin
          have_prev <= (nxt != '0);
          state     <= (nxt != '0) ? S_GET_PREV : S_NB_NEXT;
        end
        S_GET_PREV: begin
          prev_first <= rd_first;
          prev_last  <= rd_last;
          state      <= S_NB_NEXT;
        end
        S_NB_NEXT: begin
          have_next <= (nxt < n);
          state     <= (nxt < n) ? S_GET_NEXT : S_DECIDE;
        end
        S_GET_NEXT: begin
          next_first <= rd_first;
          next_last  <= rd_last;
          state      <= S_DECIDE;
        end
        S_DECIDE: begin
          rd_pend <= 1'b0;
          priority if (d_cov) begin
            state <= S_IDLE;
          end else if (d_gp && d_gn) begin
            // Close the gap left by the absorbed range.
            is_join <= 1'b1;
            src     <= nxt + ONE_C;
            cnt     <= n - nxt - ONE_C;
            state   <= S_SHIFT;
          end else if (d_gp || d_gn || d_full) begin
            state <= S_IDLE;
          end else begin
            // Open a slot at nxt by moving the upper ranges up by one.
            is_join <= 1'b0;
            src     <= n - ONE_C;
            cnt     <= n - nxt;
            state   <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          rd_pend <= (cnt != '0);
          if (cnt != '0) begin
            dst <= is_join ? (src - ONE_C) : (src + ONE_C);
            src <= is_join ? (src + ONE_C) : (src - ONE_C);
            cnt <= cnt - ONE_C;
          end else if (!rd_pend) begin
            n     <= is_join ? (n - ONE_C) : (n + ONE_C);
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  `CIS_ASSERT_HOLDS(a_count_max, clk, rst, 1'b1, n <= MAX_CNT, "range count above capacity")
  `CIS_ASSERT_HOLDS(a_bs_window, clk, rst, state == S_BS, (lo <= hi) && (hi <= n), "search window out of bounds")
  `CIS_ASSERT_HOLDS(a_room_for_new, clk, rst, (state == S_SHIFT) && !is_join, n != MAX_CNT, "new range opened in a full table")
  `CIS_ASSERT_NEXT(a_clear_empties, clk, rst, (state == S_IDLE) && start && (cmd.opcode == cis_pkg::OP_CLEAR), (n == '0) && (state == S_IDLE), "clear left ranges behind")

endmodule

`default_nettype wire

// ===== hw/rtl/coalescing_interval_set_top.sv =====
// Top level of the coalescing interval set: sequencer, range RAM and result register.
// Depends on cis_pkg, cis_ram and cis_ctrl.
`default_nettype none

// A command beat is taken when start is high and busy is low; busy stays high until
// the command is finished. Each command gives one result beat, shown on result for a
// single cycle with strobe high; the receiver cannot stall it, so it must take every
// beat as it comes. Clear, unused opcodes and a read past the held ranges: strobe in the
// cycle after the command. Read of a held slot: strobe after the registered RAM read and
// the result register. Insert: a binary search over the held ranges, a fetch of the two
// neighbors, a decision, and for a new range or a join a shift that moves the ranges
// above the slot one by one, all through the single RAM port pair.
module coalescing_interval_set_top #(
  parameter int MAX_RANGES = cis_pkg::MAX_RANGES_DEF,
  parameter int LINE_BITS  = cis_pkg::LINE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire cis_pkg::cmd_t cmd,
  output logic               busy,
  output logic               strobe,
  output cis_pkg::res_t      result
);

  localparam int AW = $clog2(MAX_RANGES);

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [2*LINE_BITS-1:0] ram_wdata, ram_rdata;
  cis_pkg::fin_t          fin;

  cis_ctrl #(
    .MAX_RANGES(MAX_RANGES),
    .LINE_BITS (LINE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .busy     (busy),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .fin      (fin)
  );

  // Each entry holds the first line in the upper half and the last line below it.
  cis_ram #(
    .WIDTH(2 * LINE_BITS),
    .DEPTH(MAX_RANGES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= fin.valid;
    end
    result <= fin.res;
  end

endmodule

`default_nettype wire
